// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/cwrc_pkg.sv -----
package cwrc_pkg;
    localparam int TIME_BITS_DEF = 32;
    localparam int WINDOW_FRAC_BITS_DEF = 16;

    localparam logic [1:0] OP_SENT    = 2'd0;
    localparam logic [1:0] OP_DATA    = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    localparam logic [1:0] LVL_FREE      = 2'd0;
    localparam logic [1:0] LVL_BUSY_TWO  = 2'd2;
    localparam logic [1:0] LVL_CONGESTED = 2'd3;

    localparam logic [2:0] REG_INIT_WINDOW  = 3'd0;
    localparam logic [2:0] REG_CONTROL      = 3'd1;
    localparam logic [2:0] REG_MIN_TIMEOUT  = 3'd2;
    localparam logic [2:0] REG_MAX_TIMEOUT  = 3'd3;
    localparam logic [2:0] REG_INIT_TIMEOUT = 3'd4;
    localparam logic [2:0] REG_RETRY_LIMIT  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RTT,
        ST_RTO,
        ST_WIN,
        ST_OUT
    } state_t;
endpackage

// ----- rtl/congestion_window_rto_controller.sv -----
// Congestion window and retransmit-timeout controller.
// Input channel: in_valid/in_stall carry one event beat (op, request_id,
// is_resend, congestion_level, now, outstanding, retry_count). in_stall is
// high whenever the block is busy with an event or holds an untaken result,
// and for the cycle after a write to the initial-window, control or
// initial-timeout register while the window or timeout reload lands.
// Output channel: out_valid/out_stall carry one result beat per event.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data write one register
// per beat; cfg_ready is always high. The user must make writes only while
// idle; the block does not enforce it.
// A data event runs the bit-serial restoring divider that forms 2^(2F)/window,
// one quotient bit a cycle, then one window step. An event that completes an
// RTT measurement takes two further steps for the smoothed RTT and its
// variance before the window step. Other events present their result the
// cycle after acceptance.
// One event is in flight at a time; the next beat is taken no earlier than
// the cycle after the result is taken.
// Reset loads the register defaults, window one and timeout one second.
// While the receiver stalls, the result is held and no event is accepted.
module congestion_window_rto_controller
#(
    parameter int TIME_BITS = cwrc_pkg::TIME_BITS_DEF,
    parameter int WINDOW_FRAC_BITS = cwrc_pkg::WINDOW_FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          op,
    input  logic [31:0]         request_id,
    input  logic                is_resend,
    input  logic [1:0]          congestion_level,
    input  logic [31:0]         now,
    input  logic [15:0]         outstanding,
    input  logic [7:0]          retry_count,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         window_now,
    output logic signed [16:0]  send_credit,
    output logic [31:0]         timeout_now,
    output logic [31:0]         smoothed_rtt,
    output logic [31:0]         rtt_variance,
    output logic                rtt_updated,
    output logic                abort_request,
    output logic [15:0]         congested_run,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import cwrc_pkg::*;
    `include "assert_macros.svh"

    localparam int F = WINDOW_FRAC_BITS;
    localparam int DB = 2 * F + 1;
    localparam int CW = $clog2(DB + 1);
    localparam logic [31:0] WIN_ONE = 32'(64'd1 << F);
    localparam logic [TIME_BITS-1:0] TB = '0;

    logic [15:0] initw_reg;
    logic        ctrl_reg;
    logic [31:0] mint_reg, maxt_reg, initt_reg;
    logic [7:0]  rlim_reg;
    logic        cfgw_reg, cfgt_reg;

    logic [31:0] win_reg, win_next, tmo_reg, tmo_next, srtt_reg, srtt_next;
    logic [31:0] var_reg, var_next;
    logic        meas_reg, meas_next;
    logic [31:0] mid_reg, mid_next;
    logic [TIME_BITS-1:0] mstart_reg, mstart_next, ldbl_reg, ldbl_next;
    logic [TIME_BITS-1:0] lhalf_reg, lhalf_next;
    logic [15:0] ccnt_reg, ccnt_next;

    state_t state_reg, state_next;
    logic [1:0]  lvl_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [15:0] outs_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [32:0] rem_reg, rem_next;
    logic [DB-1:0] quo_reg, quo_next;
    logic [32:0] rtt_reg, rtt_next;
    logic        upd_reg, upd_next, abt_reg, abt_next;

    logic [31:0] wdiv, init_win;
    logic [33:0] trial;
    logic [TIME_BITS-1:0] tnow;
    logic [TIME_BITS-1:0] dt;
    logic [31:0] dt32;
    logic [35:0] sum;
    logic [32:0] errv;
    logic [16:0] whole;
    logic signed [17:0] cred;

    assign tnow = TIME_BITS'(now);
    assign cfg_ready = 1'b1;
    assign in_stall = (state_reg != ST_IDLE) || cfgw_reg || cfgt_reg;
    assign out_valid = (state_reg == ST_OUT);
    assign wdiv = (win_reg == 32'd0) ? 32'd1 : win_reg;
    assign trial = {rem_reg, quo_reg[DB-1]} - {2'b00, wdiv};

    always_comb
    begin
        logic [47:0] w48;
        w48 = 48'(initw_reg) << F;
        if (w48 < 48'(WIN_ONE))
            init_win = WIN_ONE;
        else if (w48 > 48'hFFFF_FFFF)
            init_win = 32'hFFFF_FFFF;
        else
            init_win = w48[31:0];
        if (!ctrl_reg)
            init_win = 32'hFFFF_FFFF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initw_reg <= 16'd1;
            ctrl_reg <= 1'b1;
            mint_reg <= 32'd500000;
            maxt_reg <= 32'd1000000;
            initt_reg <= 32'd1000000;
            rlim_reg <= 8'd12;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_INIT_WINDOW: initw_reg <= cfg_data[15:0];
                REG_CONTROL: ctrl_reg <= cfg_data[0];
                REG_MIN_TIMEOUT: mint_reg <= cfg_data;
                REG_MAX_TIMEOUT: maxt_reg <= cfg_data;
                REG_INIT_TIMEOUT: initt_reg <= cfg_data;
                REG_RETRY_LIMIT: rlim_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Reload flags, registered on a write to the initial-window, control or initial-timeout register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfgw_reg <= 1'b0;
            cfgt_reg <= 1'b0;
        end
        else
        begin
            cfgw_reg <= cfg_valid && (cfg_index == REG_INIT_WINDOW
                || cfg_index == REG_CONTROL);
            cfgt_reg <= cfg_valid && (cfg_index == REG_INIT_TIMEOUT);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        win_next = win_reg;
        tmo_next = tmo_reg;
        srtt_next = srtt_reg;
        var_next = var_reg;
        meas_next = meas_reg;
        mid_next = mid_reg;
        mstart_next = mstart_reg;
        ldbl_next = ldbl_reg;
        lhalf_next = lhalf_reg;
        ccnt_next = ccnt_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        rtt_next = rtt_reg;
        upd_next = upd_reg;
        abt_next = abt_reg;
        dt = '0;
        dt32 = '0;
        sum = '0;
        errv = '0;
        if (cfgw_reg)
            win_next = init_win;
        if (cfgt_reg)
            tmo_next = (initt_reg == 32'd0) ? 32'd1 : initt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    upd_next = 1'b0;
                    abt_next = 1'b0;
                    cnt_next = '0;
                    rem_next = '0;
                    quo_next = DB'(1) << (DB - 1);
                    case (op)
                        OP_SENT:
                        begin
                            if (!meas_reg && !is_resend)
                            begin
                                meas_next = 1'b1;
                                mid_next = request_id;
                                mstart_next = tnow;
                            end
                            state_next = ST_OUT;
                        end
                        OP_DATA:
                        begin
                            if (meas_reg && mid_reg == request_id)
                            begin
                                dt = tnow - mstart_reg;
                                dt32 = (TIME_BITS > 32 && (dt >> 32) != TB)
                                    ? 32'hFFFF_FFFF : 32'(dt);
                                rtt_next = {1'b1, dt32};
                                meas_next = 1'b0;
                            end
                            else
                                rtt_next = '0;
                            if (congestion_level == LVL_CONGESTED)
                            begin
                                if (ccnt_reg != 16'hFFFF)
                                    ccnt_next = ccnt_reg + 16'd1;
                            end
                            else
                                ccnt_next = '0;
                            state_next = ST_DIV;
                        end
                        OP_TIMEOUT:
                        begin
                            if (meas_reg && mid_reg == request_id)
                                meas_next = 1'b0;
                            if (retry_count > rlim_reg)
                                abt_next = 1'b1;
                            else
                            begin
                                dt = tnow - ldbl_reg;
                                if (dt > TIME_BITS'(tmo_reg))
                                begin
                                    sum = {3'b000, tmo_reg, 1'b0};
                                    tmo_next = (sum > 36'(maxt_reg))
                                        ? maxt_reg : sum[31:0];
                                    ldbl_next = tnow;
                                end
                            end
                            state_next = ST_OUT;
                        end
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (!trial[33])
                    rem_next = trial[32:0];
                else
                    rem_next = {rem_reg[31:0], quo_reg[DB-1]};
                quo_next = {quo_reg[DB-2:0], ~trial[33]};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DB - 1))
                    state_next = rtt_reg[32] ? ST_RTT : ST_WIN;
            end
            ST_RTT:
            begin
                errv = (rtt_reg[31:0] >= srtt_reg) ? 33'(rtt_reg[31:0] - srtt_reg)
                    : 33'(srtt_reg - rtt_reg[31:0]);
                sum = (36'(srtt_reg) << 3) - 36'(srtt_reg) + 36'(rtt_reg[31:0]);
                srtt_next = sum[34:3];
                rtt_next = {1'b1, errv[31:0]};
                state_next = ST_RTO;
            end
            ST_RTO:
            begin
                sum = (36'(var_reg) << 3) - 36'(var_reg) + 36'(rtt_reg[31:0]);
                var_next = sum[34:3];
                rtt_next = '0;
                upd_next = 1'b1;
                state_next = ST_WIN;
            end
            ST_WIN:
            begin
                if (upd_reg && rtt_reg == '0)
                begin
                    sum = 36'(srtt_reg) + (36'(var_reg) << 2);
                    if (sum > 36'(maxt_reg))
                        sum = 36'(maxt_reg);
                    if (sum < 36'(mint_reg))
                        sum = 36'(mint_reg);
                    tmo_next = sum[31:0];
                end
                sum = 36'(win_reg);
                case (lvl_reg)
                    LVL_FREE:
                    begin
                        sum = 36'(win_reg) + 36'(quo_reg);
                        if (sum > 36'hFFFF_FFFF)
                            sum = 36'hFFFF_FFFF;
                    end
                    LVL_BUSY_TWO:
                        sum = (36'(win_reg) > 36'(quo_reg))
                            ? 36'(win_reg) - 36'(quo_reg) : 36'd0;
                    LVL_CONGESTED:
                    begin
                        if ((now_reg - lhalf_reg) > TIME_BITS'(srtt_reg))
                        begin
                            lhalf_next = now_reg;
                            sum = 36'(win_reg >> 1);
                        end
                    end
                    default: ;
                endcase
                if (sum < 36'(WIN_ONE))
                    sum = 36'(WIN_ONE);
                if (!ctrl_reg)
                    sum = 36'hFFFF_FFFF;
                win_next = sum[31:0];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            win_reg <= WIN_ONE;
            tmo_reg <= 32'd1000000;
            srtt_reg <= '0;
            var_reg <= '0;
            meas_reg <= 1'b0;
            mid_reg <= '0;
            mstart_reg <= '0;
            ldbl_reg <= '0;
            lhalf_reg <= '0;
            ccnt_reg <= '0;
            cnt_reg <= '0;
            upd_reg <= 1'b0;
            abt_reg <= 1'b0;
            rtt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            win_reg <= win_next;
            tmo_reg <= tmo_next;
            srtt_reg <= srtt_next;
            var_reg <= var_next;
            meas_reg <= meas_next;
            mid_reg <= mid_next;
            mstart_reg <= mstart_next;
            ldbl_reg <= ldbl_next;
            lhalf_reg <= lhalf_next;
            ccnt_reg <= ccnt_next;
            cnt_reg <= cnt_next;
            upd_reg <= upd_next;
            abt_reg <= abt_next;
            rtt_reg <= rtt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (in_valid && !in_stall)
        begin
            lvl_reg <= congestion_level;
            now_reg <= tnow;
            outs_reg <= outstanding;
        end
    end

    assign whole = ((win_reg >> F) > 32'd65535) ? 17'd65535 : 17'(win_reg >> F);
    assign cred = $signed({1'b0, whole}) - $signed({2'b00, outs_reg});
    assign window_now = win_reg;
    assign send_credit = (cred < -18'sd65535) ? -17'sd65535 : cred[16:0];
    assign timeout_now = tmo_reg;
    assign smoothed_rtt = srtt_reg;
    assign rtt_variance = var_reg;
    assign rtt_updated = upd_reg;
    assign abort_request = abt_reg;
    assign congested_run = ccnt_reg;

    `ASSERT_IMPLIES(a_win_floor, clk, rst_n, out_valid, win_reg >= WIN_ONE)
    `ASSERT_IMPLIES(a_abort_upd, clk, rst_n, out_valid, !(abt_reg && upd_reg))
    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(win_reg))
    `ASSERT_IMPLIES(a_cnt, clk, rst_n, state_reg == ST_DIV, cnt_reg < CW'(DB))
endmodule

// ----- verif/tb_congestion_window_rto_controller.sv -----
`default_nettype none

import cwrc_pkg::*;

typedef struct packed {
    logic [31:0]        window_now;
    logic signed [16:0] send_credit;
    logic [31:0]        timeout_now;
    logic [31:0]        smoothed_rtt;
    logic [31:0]        rtt_variance;
    logic               rtt_updated;
    logic               abort_request;
    logic [15:0]        congested_run;
} cw_result_t;

class rto_scoreboard;
    localparam logic [32:0] WIN_ONE = 33'h1_0000;
    localparam logic [32:0] WIN_MAX = 33'h0_FFFF_FFFF;

    logic [15:0] init_window;
    logic        control_on;
    logic [31:0] min_rto;
    logic [31:0] max_rto;
    logic [31:0] init_rto;
    logic [7:0]  retry_limit;

    logic [31:0] window;
    logic [31:0] rto;
    logic [31:0] srtt;
    logic [31:0] rttvar;
    logic        measuring;
    logic [31:0] measured_id;
    logic [31:0] measure_start;
    logic [31:0] last_doubled;
    logic [31:0] last_halved;
    logic [15:0] congested_count;

    cw_result_t expected_results[$];
    int errors;

    function new();
        init_window = 16'd1;
        control_on = 1'b1;
        min_rto = 32'd500000;
        max_rto = 32'd1000000;
        init_rto = 32'd1000000;
        retry_limit = 8'd12;
        reload_window();
        rto = init_rto;
        srtt = '0;
        rttvar = '0;
        measuring = 1'b0;
        measured_id = '0;
        measure_start = '0;
        last_doubled = '0;
        last_halved = '0;
        congested_count = '0;
        errors = 0;
    endfunction

    function void reload_window();
        logic [32:0] w;
        w = {1'b0, init_window, 16'h0};
        if (w < WIN_ONE)
        begin
            w = WIN_ONE;
        end
        window = control_on ? w[31:0] : WIN_MAX[31:0];
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            REG_INIT_WINDOW:
            begin
                init_window = data[15:0];
                reload_window();
            end
            REG_CONTROL:
            begin
                control_on = data[0];
                reload_window();
            end
            REG_MIN_TIMEOUT: min_rto = data;
            REG_MAX_TIMEOUT: max_rto = data;
            REG_INIT_TIMEOUT:
            begin
                init_rto = data;
                rto = (data == 0) ? 32'd1 : data;
            end
            REG_RETRY_LIMIT: retry_limit = data[7:0];
            default: ;
        endcase
    endfunction

    function logic [63:0] window_step();
        logic [63:0] w;
        w = (window == 0) ? 64'd1 : {32'd0, window};
        return (64'd1 << 32) / w;
    endfunction

    function void note_event(logic [1:0] op, logic [31:0] id, logic resend, logic [1:0] lvl,
                             logic [31:0] t, logic [15:0] outst, logic [7:0] retries);
        cw_result_t r;
        logic [63:0] w;
        logic [63:0] s;
        logic [63:0] sample;
        logic [63:0] err;
        logic [63:0] x;
        logic [31:0] whole;
        int credit;
        r = '0;
        if (op == OP_SENT)
        begin
            if (!measuring && !resend)
            begin
                measuring = 1'b1;
                measured_id = id;
                measure_start = t;
            end
        end
        else if (op == OP_DATA)
        begin
            w = {32'd0, window};
            if (measuring && measured_id == id)
            begin
                sample = {32'd0, t - measure_start};
                err = (sample >= srtt) ? sample - srtt : 64'(srtt) - sample;
                srtt = 32'((64'd7 * srtt + sample) >> 3);
                rttvar = 32'((64'd7 * rttvar + err) >> 3);
                x = {32'd0, srtt} + 64'd4 * rttvar;
                if (x > max_rto)
                begin
                    x = 64'(max_rto);
                end
                if (x < min_rto)
                begin
                    x = 64'(min_rto);
                end
                rto = x[31:0];
                measuring = 1'b0;
                r.rtt_updated = 1'b1;
            end
            if (lvl == LVL_CONGESTED)
            begin
                if (congested_count != 16'hFFFF)
                begin
                    congested_count++;
                end
            end
            else
            begin
                congested_count = '0;
            end
            if (lvl == LVL_FREE)
            begin
                w = w + window_step();
                if (w > WIN_MAX)
                begin
                    w = 64'(WIN_MAX);
                end
            end
            else if (lvl == LVL_BUSY_TWO)
            begin
                s = window_step();
                w = (w > s) ? w - s : 64'd0;
            end
            else if (lvl == LVL_CONGESTED)
            begin
                if (32'(t - last_halved) > srtt)
                begin
                    last_halved = t;
                    w = w >> 1;
                end
            end
            if (w < WIN_ONE)
            begin
                w = 64'(WIN_ONE);
            end
            if (!control_on)
            begin
                w = 64'(WIN_MAX);
            end
            window = w[31:0];
        end
        else if (op == OP_TIMEOUT)
        begin
            if (measuring && measured_id == id)
            begin
                measuring = 1'b0;
            end
            if (retries > retry_limit)
            begin
                r.abort_request = 1'b1;
            end
            else if (32'(t - last_doubled) > rto)
            begin
                x = 64'd2 * rto;
                if (x > max_rto)
                begin
                    x = 64'(max_rto);
                end
                rto = x[31:0];
                last_doubled = t;
            end
        end
        whole = window >> 16;
        credit = int'(whole) - int'(outst);
        r.window_now = window;
        r.send_credit = 17'(credit);
        r.timeout_now = rto;
        r.smoothed_rtt = srtt;
        r.rtt_variance = rttvar;
        r.congested_run = congested_count;
        expected_results.push_back(r);
    endfunction

    function void check_result(cw_result_t got);
        cw_result_t e;
        if (expected_results.size() == 0)
        begin
            $error("result beat with nothing expected");
            errors++;
            return;
        end
        e = expected_results.pop_front();
        if (got.window_now !== e.window_now)
        begin
            $error("window_now: expected %h, got %h", e.window_now, got.window_now);
            errors++;
        end
        if (got.send_credit !== e.send_credit)
        begin
            $error("send_credit: expected %0d, got %0d", e.send_credit, got.send_credit);
            errors++;
        end
        if (got.timeout_now !== e.timeout_now)
        begin
            $error("timeout_now: expected %0d, got %0d", e.timeout_now, got.timeout_now);
            errors++;
        end
        if (got.smoothed_rtt !== e.smoothed_rtt)
        begin
            $error("smoothed_rtt: expected %0d, got %0d", e.smoothed_rtt, got.smoothed_rtt);
            errors++;
        end
        if (got.rtt_variance !== e.rtt_variance)
        begin
            $error("rtt_variance: expected %0d, got %0d", e.rtt_variance, got.rtt_variance);
            errors++;
        end
        if (got.rtt_updated !== e.rtt_updated)
        begin
            $error("rtt_updated: expected %0d, got %0d", e.rtt_updated, got.rtt_updated);
            errors++;
        end
        if (got.abort_request !== e.abort_request)
        begin
            $error("abort_request: expected %0d, got %0d", e.abort_request, got.abort_request);
            errors++;
        end
        if (got.congested_run !== e.congested_run)
        begin
            $error("congested_run: expected %0d, got %0d", e.congested_run, got.congested_run);
            errors++;
        end
    endfunction
endclass

module tb_congestion_window_rto_controller;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] LVL_BUSY_ONE = 2'd1;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] op = '0;
    logic [31:0] request_id = '0;
    logic is_resend = 1'b0;
    logic [1:0] congestion_level = '0;
    logic [31:0] now = '0;
    logic [15:0] outstanding = '0;
    logic [7:0] retry_count = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [31:0] window_now;
    logic signed [16:0] send_credit;
    logic [31:0] timeout_now;
    logic [31:0] smoothed_rtt;
    logic [31:0] rtt_variance;
    logic rtt_updated;
    logic abort_request;
    logic [15:0] congested_run;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    rto_scoreboard sb = new();
    bit quiet = 1'b0;
    int idle_cycles = 0;
    int events_sent = 0;
    logic [31:0] clock_us = '0;
    logic [31:0] next_id = 32'd100;

    congestion_window_rto_controller dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .request_id(request_id),
        .is_resend(is_resend),
        .congestion_level(congestion_level),
        .now(now),
        .outstanding(outstanding),
        .retry_count(retry_count),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .window_now(window_now),
        .send_credit(send_credit),
        .timeout_now(timeout_now),
        .smoothed_rtt(smoothed_rtt),
        .rtt_variance(rtt_variance),
        .rtt_updated(rtt_updated),
        .abort_request(abort_request),
        .congested_run(congested_run),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 19);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result({window_now, send_credit, timeout_now, smoothed_rtt,
                             rtt_variance, rtt_updated, abort_request, congested_run});
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_congestion_window_rto_controller: FAIL");
                $finish;
            end
        end
    end

    task automatic send_event(logic [1:0] o, logic [31:0] id, logic rs, logic [1:0] lvl,
                              logic [31:0] t, logic [15:0] outst, logic [7:0] rc);
        if (!quiet && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        request_id <= id;
        is_resend <= rs;
        congestion_level <= lvl;
        now <= t;
        outstanding <= outst;
        retry_count <= rc;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_event(o, id, rs, lvl, t, outst, rc);
        events_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_events(int count);
        int target;
        logic [31:0] id;
        target = events_sent + count;
        while (events_sent < target)
        begin
            clock_us = clock_us + $urandom_range(0, 3000);
            if ($urandom_range(99) < 75)
            begin
                id = ($urandom_range(3) == 0) ? $urandom() : next_id;
                next_id++;
                send_event(OP_SENT, id, $urandom_range(7) == 0, 2'($urandom()), clock_us,
                           16'($urandom()), 8'($urandom()));
                if ($urandom_range(4) == 0)
                begin
                    send_event(OP_SENT, $urandom(), 1'($urandom()), 2'($urandom()), clock_us,
                               16'($urandom()), 8'($urandom()));
                end
                if ($urandom_range(9) == 0)
                begin
                    clock_us = clock_us + $urandom();
                end
                else
                begin
                    clock_us = clock_us + $urandom_range(1, 1500000);
                end
                if ($urandom_range(7) == 0)
                begin
                    send_event(OP_TIMEOUT, id, 1'($urandom()), 2'($urandom()), clock_us,
                               16'($urandom()), 8'($urandom_range(0, 20)));
                end
                send_event(OP_DATA, ($urandom_range(9) == 0) ? $urandom() : id,
                           1'($urandom()), 2'($urandom()), clock_us,
                           16'($urandom_range(0, 70)), 8'($urandom()));
            end
            else
            begin
                send_event(2'($urandom()), $urandom(), 1'($urandom()), 2'($urandom()),
                           ($urandom_range(3) == 0) ? $urandom() : clock_us,
                           16'($urandom()), 8'($urandom()));
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_event(OP_SENT, 32'h0, 1'b1, LVL_FREE, 32'd10, 16'd0, 8'd0);
        send_event(OP_SENT, 32'hFFFF_FFFF, 1'b0, LVL_FREE, 32'hFFFF_FF00, 16'hFFFF, 8'hFF);
        send_event(OP_SENT, 32'd5, 1'b0, LVL_FREE, 32'd20, 16'd1, 8'd0);
        send_event(OP_DATA, 32'hFFFF_FFFF, 1'b0, LVL_FREE, 32'd300, 16'd0, 8'd0);
        send_event(OP_DATA, 32'd1, 1'b1, LVL_BUSY_ONE, 32'd400, 16'hFFFF, 8'd0);
        send_event(OP_DATA, 32'd1, 1'b0, LVL_BUSY_TWO, 32'd500, 16'd3, 8'd0);
        send_event(OP_DATA, 32'd1, 1'b0, LVL_CONGESTED, 32'd600, 16'd0, 8'd0);
        send_event(OP_DATA, 32'd1, 1'b0, LVL_CONGESTED, 32'd601, 16'd0, 8'd0);
        send_event(OP_SENT, 32'd7, 1'b0, LVL_FREE, 32'd1000, 16'd0, 8'd0);
        send_event(OP_TIMEOUT, 32'd7, 1'b0, LVL_FREE, 32'd1100, 16'd0, 8'd13);
        send_event(OP_TIMEOUT, 32'd7, 1'b0, LVL_FREE, 32'd2000000, 16'd0, 8'd12);
        send_event(OP_TIMEOUT, 32'd7, 1'b0, LVL_FREE, 32'd2000001, 16'd0, 8'd1);
        send_event(OP_TIMEOUT, 32'd7, 1'b0, LVL_FREE, 32'hFFFF_FFFF, 16'd0, 8'hFF);
        send_event(OP_UNUSED, 32'd7, 1'b1, LVL_CONGESTED, 32'd0, 16'd9, 8'd0);
        drain();

        write_cfg(REG_INIT_WINDOW, 32'd65535);
        write_cfg(REG_MIN_TIMEOUT, 32'd1);
        write_cfg(REG_MAX_TIMEOUT, 32'hFFFF_FFFF);
        write_cfg(REG_INIT_TIMEOUT, 32'd0);
        write_cfg(REG_RETRY_LIMIT, 32'd255);
        write_cfg(3'd6, 32'hFFFF_FFFF);
        send_event(OP_DATA, 32'd0, 1'b0, LVL_FREE, 32'd50, 16'd0, 8'd0);
        send_event(OP_SENT, 32'd9, 1'b0, LVL_FREE, 32'h0000_0010, 16'd0, 8'd0);
        send_event(OP_DATA, 32'd9, 1'b0, LVL_BUSY_TWO, 32'h0000_000F, 16'd0, 8'd0);
        send_event(OP_TIMEOUT, 32'd9, 1'b0, LVL_FREE, 32'h8000_0000, 16'd0, 8'd255);
        random_events(100);
        drain();

        quiet = 1'b1;
        write_cfg(REG_CONTROL, 32'd0);
        write_cfg(3'd7, 32'd0);
        random_events(80);
        drain();
        quiet = 1'b0;

        write_cfg(REG_CONTROL, 32'd1);
        write_cfg(REG_INIT_WINDOW, 32'd0);
        write_cfg(REG_MIN_TIMEOUT, 32'd500000);
        write_cfg(REG_MAX_TIMEOUT, 32'd1000000);
        write_cfg(REG_INIT_TIMEOUT, 32'hFFFF_FFFF);
        write_cfg(REG_RETRY_LIMIT, 32'd0);
        random_events(130);
        drain();

        write_cfg(REG_INIT_WINDOW, 32'd4);
        write_cfg(REG_MIN_TIMEOUT, 32'd2000000);
        write_cfg(REG_MAX_TIMEOUT, 32'd300000);
        write_cfg(REG_INIT_TIMEOUT, 32'd1000);
        write_cfg(REG_RETRY_LIMIT, 32'd8);
        random_events(130);
        drain();

        write_cfg(REG_INIT_WINDOW, 32'd32);
        write_cfg(REG_MIN_TIMEOUT, 32'd200);
        write_cfg(REG_MAX_TIMEOUT, 32'd60000000);
        write_cfg(REG_INIT_TIMEOUT, 32'd3000000);
        write_cfg(REG_RETRY_LIMIT, 32'd12);
        random_events(160);
        drain();

        if (sb.errors == 0 && sb.expected_results.size() == 0)
        begin
            $display("tb_congestion_window_rto_controller: PASS");
        end
        else
        begin
            $display("tb_congestion_window_rto_controller: FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/cwrc_pkg.sv
rtl/congestion_window_rto_controller.sv
verif/tb_congestion_window_rto_controller.sv
